// ===== hdl/u8d_pkg.sv =====
// shared types and constants for the lenient utf-8 decoder
// no dependencies; imported by u8d_decode, u8d_burst and utf8_lenient_decoder_unit

package u8d_pkg;

   localparam int unsigned BurstDepth = 4;

   // byte tags
   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;

   // continuation bytes needed in total by the open sequence
   localparam logic [1:0] NEED_NONE  = 2'd0;
   localparam logic [1:0] NEED_ONE   = 2'd1;
   localparam logic [1:0] NEED_TWO   = 2'd2;
   localparam logic [1:0] NEED_THREE = 2'd3;

   typedef logic [20:0] cp_type;

   typedef struct packed {
      logic [7:0]      lead;
      logic [1:0][7:0] cont;
      logic [1:0]      needed;
      logic [1:0]      have;
   } seq_type;

   // results caused by one item, in order from slot 0
   typedef struct packed {
      logic [BurstDepth-1:0][20:0] cp;
      logic [BurstDepth-1:0]       eot;
      logic [2:0]                  count;
   } burst_type;

endpackage

// ===== hdl/u8d_decode.sv =====
// decode logic: one byte plus the open-sequence state gives the burst of results
// and the next sequence state; depends on u8d_pkg

module u8d_decode (
   input  logic [7:0]         byte_in,
   input  u8d_pkg::seq_type   seq_cur,
   output u8d_pkg::seq_type   seq_nxt,
   output u8d_pkg::burst_type burst
);
   import u8d_pkg::*;

   logic                        open;
   logic                        is_cont;
   logic [2:0]                  have_ext;
   logic [2:0]                  need_ext;
   logic [2:0]                  flush;
   logic                        fresh_emit;
   logic                        fresh_eot;
   logic                        fresh_lead;
   logic [1:0]                  fresh_need;
   cp_type                      acc;
   logic [BurstDepth-1:0][20:0] flush_cp;

   assign open     = seq_cur.needed != NEED_NONE;
   assign is_cont  = byte_in[7:6] == CONT_TAG;
   assign have_ext = {1'b0, seq_cur.have};
   assign need_ext = {1'b0, seq_cur.needed};

   // raw bytes of a broken sequence, arrival order
   assign flush_cp[0] = {13'b0, seq_cur.lead};
   assign flush_cp[1] = {13'b0, seq_cur.cont[0]};
   assign flush_cp[2] = {13'b0, seq_cur.cont[1]};
   assign flush_cp[3] = '0;

   always_comb begin
      unique case (seq_cur.needed)
         NEED_ONE:   acc = {10'b0, seq_cur.lead[4:0], byte_in[5:0]};
         NEED_TWO:   acc = {5'b0, seq_cur.lead[3:0], seq_cur.cont[0][5:0], byte_in[5:0]};
         NEED_THREE: acc = {seq_cur.lead[2:0], seq_cur.cont[0][5:0],
                            seq_cur.cont[1][5:0], byte_in[5:0]};
         default:    acc = '0;
      endcase
   end

   // how the byte is handled as a fresh byte
   always_comb begin
      fresh_emit = 1'b1;
      fresh_eot  = 1'b0;
      fresh_lead = 1'b0;
      fresh_need = NEED_NONE;
      if (byte_in == 8'd0) begin
         fresh_eot = 1'b1;
      end else if (byte_in[7:5] == LEAD2_TAG) begin
         fresh_emit = 1'b0;
         fresh_lead = 1'b1;
         fresh_need = NEED_ONE;
      end else if (byte_in[7:4] == LEAD3_TAG) begin
         fresh_emit = 1'b0;
         fresh_lead = 1'b1;
         fresh_need = NEED_TWO;
      end else if (byte_in[7:3] == LEAD4_TAG) begin
         fresh_emit = 1'b0;
         fresh_lead = 1'b1;
         fresh_need = NEED_THREE;
      end
   end

   assign flush = open ? (3'd1 + have_ext) : 3'd0;

   always_comb begin
      burst   = '0;
      seq_nxt = seq_cur;
      if (open && is_cont) begin
         if (have_ext + 3'd1 >= need_ext) begin
            burst.count = 3'd1;
            burst.cp[0] = acc;
            seq_nxt     = '0;
         end else begin
            seq_nxt.cont[seq_cur.have[0]] = byte_in;
            seq_nxt.have                  = seq_cur.have + 2'd1;
         end
      end else begin
         seq_nxt = '0;
         if (fresh_lead) begin
            seq_nxt.lead   = byte_in;
            seq_nxt.needed = fresh_need;
         end
         for (int j = 0; j < BurstDepth; j++) begin
            if (3'(j) < flush) begin
               burst.cp[j] = flush_cp[j];
            end else if (3'(j) == flush && fresh_emit) begin
               // a zero byte reports code point 0
               burst.cp[j]  = fresh_eot ? '0 : {13'b0, byte_in};
               burst.eot[j] = fresh_eot;
            end
         end
         burst.count = flush + {2'b0, fresh_emit};
      end
   end

endmodule

// ===== hdl/u8d_burst.sv =====
// result buffer: holds the results of one item and hands them out one per cycle
// through the output register while rsp_stall is low; depends on u8d_pkg

module u8d_burst (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  u8d_pkg::burst_type burst,
   output logic               can_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output u8d_pkg::cp_type    rsp_code_point,
   output logic               rsp_end_of_text,
   output logic               rsp_is_last
);
   import u8d_pkg::*;

   burst_type buf_ff, buf_in;
   logic      valid_ff, valid_in;
   cp_type    cp_ff;
   logic      eot_ff;
   logic      last_ff;
   logic      out_load;

   assign out_load = (buf_ff.count != 3'd0) && (!valid_ff || !rsp_stall);
   assign can_take = (buf_ff.count == 3'd0) || ((buf_ff.count == 3'd1) && out_load);

   always_comb begin
      buf_in   = buf_ff;
      valid_in = valid_ff;
      if (out_load) begin
         // shift the remaining results down one slot
         for (int j = 0; j < BurstDepth - 1; j++) begin
            buf_in.cp[j]  = buf_ff.cp[j+1];
            buf_in.eot[j] = buf_ff.eot[j+1];
         end
         buf_in.cp[BurstDepth-1]  = '0;
         buf_in.eot[BurstDepth-1] = 1'b0;
         buf_in.count             = buf_ff.count - 3'd1;
         valid_in                 = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         buf_in = burst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff.count <= 3'd0;
         valid_ff     <= 1'b0;
      end else begin
         buf_ff.count <= buf_in.count;
         valid_ff     <= valid_in;
      end
      buf_ff.cp  <= buf_in.cp;
      buf_ff.eot <= buf_in.eot;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         cp_ff   <= buf_ff.cp[0];
         eot_ff  <= buf_ff.eot[0];
         last_ff <= buf_ff.count == 3'd1;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_end_of_text = eot_ff;
   assign rsp_is_last     = last_ff;

endmodule

// ===== hdl/utf8_lenient_decoder_unit.sv =====
// lenient utf-8 decoder, top level: sequence state registers, decode logic and
// result buffer; depends on u8d_pkg, u8d_decode and u8d_burst
//
// req channel: one text byte per item (req_byte_in), zero ends the text.
// rsp channel: one code point per item with end_of_text and is_last flags;
//    is_last marks the final result caused by one input byte.
// a byte gives zero to four results: a lead or a pending continuation gives
//    none, a broken sequence flushes its held bytes raw before the new byte.
// a result passes through the buffer register, loaded at the accepting edge, and then
//    the output register; further results of the same byte follow one per cycle
//    while rsp_stall is low.
// throughput: one byte per cycle while each byte gives at most one result and the
//    receiver does not stall; a byte with more results holds req_stall high while the
//    single output register drains the result buffer.
// a stalled receiver holds the output register; the buffer behind it keeps the
//    pending results and req_stall rises once the buffer cannot be refilled.
// reset closes any open sequence and empties the buffer and output register.

module utf8_lenient_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_byte_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [20:0]            rsp_code_point,
   output logic                   rsp_end_of_text,
   output logic                   rsp_is_last
);
   import u8d_pkg::*;

   seq_type   seq_ff, seq_in;
   burst_type burst;
   logic      can_take;
   logic      accept;

   assign req_stall = !can_take;
   assign accept    = req_valid && can_take;

   u8d_decode u_decode (
      .byte_in (req_byte_in),
      .seq_cur (seq_ff),
      .seq_nxt (seq_in),
      .burst   (burst)
   );

   u8d_burst u_burst (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .burst           (burst),
      .can_take        (can_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_is_last     (rsp_is_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff.needed <= NEED_NONE;
         seq_ff.have   <= 2'd0;
      end else if (accept) begin
         seq_ff.needed <= seq_in.needed;
         seq_ff.have   <= seq_in.have;
      end
      if (accept) begin
         seq_ff.lead <= seq_in.lead;
         seq_ff.cont <= seq_in.cont;
      end
   end

   // an open sequence always lacks at least one continuation
   a_have_below_need: assert property (@(posedge clock) disable iff (reset)
      seq_ff.needed != NEED_NONE |-> seq_ff.have < seq_ff.needed)
      else $error("held continuation count reached needed count");

   // end result is the last result of its byte and carries code point 0
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_text |-> rsp_is_last && rsp_code_point == 21'd0)
      else $error("end of text result malformed");

   // results of one byte follow without a gap
   a_burst_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_is_last |=> rsp_valid)
      else $error("gap inside the results of one item");

   // no new byte while the output is stalled and results of its byte are still queued behind it
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last && rsp_stall |-> req_stall)
      else $error("byte accepted while results still pending");

endmodule
